// ===== sv/scalar_kalman_filter_top_macros.svh =====
// Assertion macros for the scalar Kalman filter.
// Used by scalar_kalman_filter_top; no other dependencies.
`ifndef SCALAR_KALMAN_FILTER_TOP_MACROS_SVH
`define SCALAR_KALMAN_FILTER_TOP_MACROS_SVH

// same-cycle implication
`define SKF_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SKF_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/skf_pkg.sv =====
// Shared constants and types for the scalar Kalman filter.
// No dependencies.
`timescale 1ns / 1ps

package skf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 32;
  localparam int DT_W      = 20;
  localparam int EXT_W     = VAL_W + 1;
  localparam int MB_W      = (DT_W > FRAC_BITS + 1) ? DT_W : FRAC_BITS + 1;
  localparam int PROD_W    = EXT_W + MB_W;
  localparam int REM_W     = EXT_W + 1;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int CNT_W     = $clog2(QUO_W);
  localparam int CFG_IDX_W = 1;

  localparam logic [VAL_W-1:0] NOISE_RESET = VAL_W'(1) << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROCESS_NOISE,
    CFG_MEAS_NOISE
  } skf_cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GROW,
    S_SUM,
    S_DIV,
    S_DIFF,
    S_MEST,
    S_EST,
    S_MVAR,
    S_VAR,
    S_DONE
  } skf_state_e;

endpackage

// ===== sv/skf_in_if.sv =====
// Input channel of the scalar Kalman filter: valid/ready plus one measurement beat.
// Depends on skf_pkg.
`timescale 1ns / 1ps

interface skf_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [skf_pkg::VAL_W-1:0]  measurement;
  logic        [skf_pkg::DT_W-1:0]   elapsed_time;
  logic                              restart;

  modport source (output valid, measurement, elapsed_time, restart, input ready);
  modport sink   (input valid, measurement, elapsed_time, restart, output ready);
endinterface

// ===== sv/skf_out_if.sv =====
// Result channel of the scalar Kalman filter: valid/ready plus one result beat.
// Depends on skf_pkg.
`timescale 1ns / 1ps

interface skf_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [skf_pkg::VAL_W-1:0]  estimate;
  logic        [skf_pkg::VAL_W-1:0]  error_variance;

  modport source (output valid, estimate, error_variance, input ready);
  modport sink   (input valid, estimate, error_variance, output ready);
endinterface

// ===== sv/scalar_kalman_filter_top.sv =====
// Scalar Kalman filter, random-walk model, one shared multiplier and a bit-serial divider.
// Update beat: accept, GROW, SUM, gain divide in DIV (one quotient bit per cycle), then
//   DIFF, MEST, EST, MVAR, VAR and DONE; restart and zero-denominator beats skip to DONE.
// Beats are taken only in IDLE, after DONE has put the last result in the output register.
// Reset: async active low; Q = R = 1.0, estimate and variance 0, first-sample seeding armed.
// Depends on skf_pkg, skf_in_if, skf_out_if and scalar_kalman_filter_top_macros.svh.
`timescale 1ns / 1ps

module scalar_kalman_filter_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [skf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [skf_pkg::VAL_W-1:0]        cfg_data_i,
  skf_in_if.sink                           item_i,
  skf_out_if.source                        result_o
);
  import skf_pkg::*;

  skf_state_e          state_q, state_d;
  logic [VAL_W-1:0]    q_q, q_d, r_q, r_d;
  logic [VAL_W-1:0]    est_q, est_d, var_q, var_d;
  logic                first_q, first_d;
  logic                out_vld_q, out_vld_d;
  logic [VAL_W-1:0]    out_est_q, out_est_d, out_var_q, out_var_d;

  logic [VAL_W-1:0]    meas_q, meas_d;
  logic [DT_W-1:0]     dt_q, dt_d;
  logic [VAL_W-1:0]    p_q, p_d;
  logic [EXT_W-1:0]    s_q, s_d;
  logic [REM_W-1:0]    rem_q, rem_d;
  logic [QUO_W-1:0]    quo_q, quo_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [EXT_W-1:0]    mag_q, mag_d;
  logic                neg_q, neg_d;
  logic [PROD_W-1:0]   prod_q, prod_d;

  logic [EXT_W-1:0]    mul_a;
  logic [MB_W-1:0]     mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [PROD_W-1:0]   prod_sh;
  logic [PROD_W:0]     grow_sum;
  logic [VAL_W-1:0]    p_sat;
  logic [EXT_W-1:0]    s_sum;
  logic                div_ge;
  logic [REM_W-1:0]    rem_sub;
  logic [EXT_W-1:0]    diff;
  logic                in_acc;

  // shared multiplier
  always_comb begin
    case (state_q)
      S_GROW:  mul_a = EXT_W'(q_q);
      S_MEST:  mul_a = mag_q;
      default: mul_a = EXT_W'(p_q);
    endcase
    case (state_q)
      S_GROW:  mul_b = MB_W'(dt_q);
      default: mul_b = MB_W'(quo_q);
    endcase
  end

  assign mul_p    = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign prod_sh  = prod_q >> FRAC_BITS;
  assign grow_sum = {1'b0, prod_sh} + (PROD_W + 1)'(var_q);
  assign p_sat    = (|grow_sum[PROD_W:VAL_W]) ? '1 : grow_sum[VAL_W-1:0];
  assign s_sum    = EXT_W'(p_sat) + EXT_W'(r_q);
  assign div_ge   = rem_q >= REM_W'(s_q);
  assign rem_sub  = div_ge ? rem_q - REM_W'(s_q) : rem_q;
  assign diff     = {meas_q[VAL_W-1], meas_q} - {est_q[VAL_W-1], est_q};
  assign in_acc   = item_i.valid && item_i.ready;

  assign item_i.ready            = (state_q == S_IDLE);
  assign result_o.valid          = out_vld_q;
  assign result_o.estimate       = out_est_q;
  assign result_o.error_variance = out_var_q;

  always_comb begin
    state_d   = state_q;
    q_d       = q_q;
    r_d       = r_q;
    est_d     = est_q;
    var_d     = var_q;
    first_d   = first_q;
    out_vld_d = out_vld_q && !result_o.ready;
    out_est_d = out_est_q;
    out_var_d = out_var_q;
    meas_d    = meas_q;
    dt_d      = dt_q;
    p_d       = p_q;
    s_d       = s_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    cnt_d     = cnt_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    prod_d    = prod_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PROCESS_NOISE: q_d = cfg_data_i;
        CFG_MEAS_NOISE:    r_d = cfg_data_i;
        default:           ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (item_i.restart) begin
            est_d   = '0;
            var_d   = '0;
            first_d = 1'b1;
            state_d = S_DONE;
          end else begin
            meas_d  = item_i.measurement;
            dt_d    = item_i.elapsed_time;
            if (first_q) begin
              est_d = item_i.measurement;
            end
            first_d = 1'b0;
            state_d = S_GROW;
          end
        end
      end
      S_GROW: begin
        prod_d  = mul_p;
        state_d = S_SUM;
      end
      S_SUM: begin
        p_d   = p_sat;
        s_d   = s_sum;
        rem_d = REM_W'(p_sat);
        quo_d = '0;
        cnt_d = '0;
        if (s_sum == '0) begin
          // zero denominator: drop to a clean zero state
          est_d   = '0;
          var_d   = '0;
          state_d = S_DONE;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        quo_d = {quo_q[QUO_W-2:0], div_ge};
        rem_d = {rem_sub[REM_W-2:0], 1'b0};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(QUO_W - 1)) begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        neg_d   = diff[EXT_W-1];
        mag_d   = diff[EXT_W-1] ? (~diff + EXT_W'(1)) : diff;
        state_d = S_MEST;
      end
      S_MEST: begin
        prod_d  = mul_p;
        state_d = S_EST;
      end
      S_EST: begin
        est_d   = neg_q ? est_q - prod_sh[VAL_W-1:0] : est_q + prod_sh[VAL_W-1:0];
        state_d = S_MVAR;
      end
      S_MVAR: begin
        prod_d  = mul_p;
        state_d = S_VAR;
      end
      S_VAR: begin
        var_d   = p_q - prod_sh[VAL_W-1:0];
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_q || result_o.ready) begin
          out_vld_d = 1'b1;
          out_est_d = est_q;
          out_var_d = var_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      q_q       <= NOISE_RESET;
      r_q       <= NOISE_RESET;
      est_q     <= '0;
      var_q     <= '0;
      first_q   <= 1'b1;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      q_q       <= q_d;
      r_q       <= r_d;
      est_q     <= est_d;
      var_q     <= var_d;
      first_q   <= first_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_est_q <= out_est_d;
    out_var_q <= out_var_d;
    meas_q    <= meas_d;
    dt_q      <= dt_d;
    p_q       <= p_d;
    s_q       <= s_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    cnt_q     <= cnt_d;
    mag_q     <= mag_d;
    neg_q     <= neg_d;
    prod_q    <= prod_d;
  end

`include "scalar_kalman_filter_top_macros.svh"

  `SKF_ASSERT_IMP(a_gain_range, clk_i, rst_ni, state_q == S_DIFF, quo_q <= (QUO_W'(1) << FRAC_BITS), "gain above one")
  `SKF_ASSERT_NXT(a_var_shrinks, clk_i, rst_ni, state_q == S_VAR, var_q <= $past(p_q), "variance grew in update")
  `SKF_ASSERT_NXT(a_restart_clears, clk_i, rst_ni, in_acc && item_i.restart, est_q == '0 && var_q == '0 && first_q, "restart did not clear state")
  `SKF_ASSERT_IMP(a_result_from_done, clk_i, rst_ni, $rose(out_vld_q), $past(state_q) == S_DONE, "result beat outside done state")

endmodule

// ===== test/skf_result_checker.sv =====
// Scoreboard for the scalar Kalman filter: mirrors config writes, predicts each result beat.
// Depends on skf_pkg, skf_in_if and skf_out_if.
`timescale 1ns / 1ps

module skf_result_checker
  import skf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [VAL_W-1:0]     cfg_data_i,
  skf_in_if                    item_i,
  skf_out_if                   result_i,
  output int                   error_count_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [VAL_W-1:0] estimate;
    logic [VAL_W-1:0] error_variance;
  } kalman_result_t;

  logic [VAL_W-1:0] q_noise;
  logic [VAL_W-1:0] r_noise;
  logic [VAL_W-1:0] est_state;
  logic [VAL_W-1:0] var_state;
  logic             seed_pending;
  int               mismatches;
  kalman_result_t   expected_results[$];

  function automatic kalman_result_t kalman_update(input logic [VAL_W-1:0] meas,
                                                   input logic [DT_W-1:0]  dt,
                                                   input logic             restart);
    logic [63:0]        p;
    logic [63:0]        s;
    logic [63:0]        k;
    logic [63:0]        step;
    logic signed [63:0] cur;
    logic signed [63:0] diff;
    kalman_result_t     res;
    if (restart) begin
      est_state    = '0;
      var_state    = '0;
      seed_pending = 1'b1;
    end else begin
      if (seed_pending) begin
        est_state    = meas;
        seed_pending = 1'b0;
      end
      p = 64'(var_state) + ((64'(q_noise) * 64'(dt)) >> FRAC_BITS);
      if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
      s = p + 64'(r_noise);
      if (s == 64'd0) begin
        est_state = '0;
        var_state = '0;
      end else begin
        k    = (p << FRAC_BITS) / s;
        cur  = 64'($signed(est_state));
        diff = 64'($signed(meas)) - cur;
        step = (k * 64'((diff < 0) ? -diff : diff)) >> FRAC_BITS;
        cur  = (diff < 0) ? cur - $signed(step) : cur + $signed(step);
        est_state = cur[VAL_W-1:0];
        p = p - ((k * p) >> FRAC_BITS);
        var_state = p[VAL_W-1:0];
      end
    end
    res.estimate       = est_state;
    res.error_variance = var_state;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    kalman_result_t want;
    if (!rst_ni) begin
      q_noise      = NOISE_RESET;
      r_noise      = NOISE_RESET;
      est_state    = '0;
      var_state    = '0;
      seed_pending = 1'b1;
      mismatches   = 0;
      expected_results.delete();
      error_count_o <= 0;
      pending_o     <= 0;
    end else begin
      if (cfg_we_i) begin
        case (skf_cfg_idx_e'(cfg_idx_i))
          CFG_PROCESS_NOISE: q_noise = cfg_data_i;
          CFG_MEAS_NOISE:    r_noise = cfg_data_i;
          default: ;
        endcase
      end
      if (result_i.valid && result_i.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no item pending: estimate %0d, error_variance %0d",
                 $signed(result_i.estimate), result_i.error_variance);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (result_i.estimate !== want.estimate) begin
            $error("estimate: expected %0d, got %0d",
                   $signed(want.estimate), $signed(result_i.estimate));
            mismatches++;
          end
          if (result_i.error_variance !== want.error_variance) begin
            $error("error_variance: expected %0d, got %0d",
                   want.error_variance, result_i.error_variance);
            mismatches++;
          end
        end
      end
      if (item_i.valid && item_i.ready) begin
        expected_results.push_back(kalman_update(item_i.measurement, item_i.elapsed_time,
                                                 item_i.restart));
      end
      pending_o     <= expected_results.size();
      error_count_o <= mismatches;
    end
  end

endmodule

// ===== test/tb_scalar_kalman_filter_top.sv =====
// Testbench top for the scalar Kalman filter: clock, reset, config phases, bursty
// measurement beats and result stalls. Depends on skf_pkg, skf_in_if, skf_out_if,
// scalar_kalman_filter_top and skf_result_checker.
`timescale 1ns / 1ps

module tb_scalar_kalman_filter_top;
  import skf_pkg::*;

  localparam int NUM_PHASES     = 7;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_AFTER     = 30;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 40;

  typedef struct packed {
    logic [VAL_W-1:0] measurement;
    logic [DT_W-1:0]  elapsed_time;
    logic             restart;
  } skf_beat_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [VAL_W-1:0]     cfg_data_i;
  int                   error_count;
  int                   pending;
  int                   beats_sent = 0;
  int                   idle_cycles = 0;

  skf_in_if  item_if ();
  skf_out_if result_if ();

  scalar_kalman_filter_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_if),
    .result_o   (result_if)
  );

  skf_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .item_i        (item_if),
    .result_i      (result_if),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic skf_beat_t random_beat();
    skf_beat_t b;
    b.restart = ($urandom_range(0, 19) == 0);
    case ($urandom_range(0, 7))
      0:       b.measurement = 32'h7FFF_FFFF;
      1:       b.measurement = 32'h8000_0000;
      2, 3:    b.measurement = $urandom();
      default: b.measurement = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    endcase
    case ($urandom_range(0, 7))
      0:       b.elapsed_time = '0;
      1:       b.elapsed_time = 20'hF_FFFF;
      2, 3:    b.elapsed_time = DT_W'($urandom());
      default: b.elapsed_time = DT_W'($urandom_range(0, 32'h2000));
    endcase
    return b;
  endfunction

  task automatic send_beat(input skf_beat_t b);
    item_if.valid        <= 1'b1;
    item_if.measurement  <= b.measurement;
    item_if.elapsed_time <= b.elapsed_time;
    item_if.restart      <= b.restart;
    do @(posedge clk_i); while (!item_if.ready);
    beats_sent++;
  endtask

  task automatic send_random(input int count);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) send_beat(random_beat());
      left -= burst;
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 30);
        item_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain_results();
    item_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_noise(input logic [VAL_W-1:0] q, input logic [VAL_W-1:0] r);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_PROCESS_NOISE;
    cfg_data_i <= q;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MEAS_NOISE;
    cfg_data_i <= r;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin : result_stall
    int mode;
    int seg;
    bit held_off;
    held_off = 1'b0;
    result_if.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (!held_off && beats_sent >= HOLD_AFTER) begin
        held_off = 1'b1;
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        mode = $urandom_range(0, 3);
        seg  = $urandom_range(20, 200);
        for (int c = 0; c < seg; c++) begin
          case (mode)
            0:       result_if.ready <= 1'b1;
            1:       result_if.ready <= 1'($urandom_range(0, 1));
            2:       result_if.ready <= ((c % 7) >= 3);
            default: result_if.ready <= ($urandom_range(0, 7) != 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin : stimulus
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= CFG_PROCESS_NOISE;
    cfg_data_i           <= '0;
    item_if.valid        <= 1'b0;
    item_if.measurement  <= '0;
    item_if.elapsed_time <= '0;
    item_if.restart      <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: ;
        1: begin
          drain_results();
          load_noise('0, '0);
        end
        2: begin
          drain_results();
          load_noise('1, '1);
        end
        3: begin
          drain_results();
          load_noise('1, '0);
        end
        4: begin
          drain_results();
          load_noise('0, '1);
        end
        5: begin
          drain_results();
          load_noise($urandom(), $urandom());
        end
        default: begin
          drain_results();
          load_noise($urandom_range(0, 32'h4_0000), $urandom_range(1, 32'h10_0000));
        end
      endcase

      case (ph)
        0: begin
          // seeding straight out of reset, then field extremes and restarts
          send_beat('{32'h0001_0000, 20'h1_0000, 1'b0});
          send_beat('{32'h7FFF_FFFF, 20'hF_FFFF, 1'b0});
          send_beat('{32'h8000_0000, 20'h0_0000, 1'b0});
          send_beat('{32'hFFFF_FFFF, 20'hF_FFFF, 1'b1});
          send_beat('{32'h8000_0000, 20'h0_0000, 1'b0});
          send_beat('{32'h7FFF_FFFF, 20'hF_FFFF, 1'b0});
          send_beat('{32'h0000_0000, 20'h0_0001, 1'b0});
          send_beat('{32'h0000_0000, 20'h0_0000, 1'b1});
          send_beat('{32'hFFFF_FFFF, 20'h0_0000, 1'b0});
        end
        1: begin
          // Q = R = 0: zero denominator
          send_beat('{32'h1234_5678, 20'hF_FFFF, 1'b1});
          send_beat('{32'h0003_0039, 20'hF_FFFF, 1'b0});
          send_beat('{32'hFFFF_FFFB, 20'h0_0000, 1'b0});
        end
        2: begin
          send_beat('{32'h8000_0000, 20'hF_FFFF, 1'b0});
          send_beat('{32'h7FFF_FFFF, 20'hF_FFFF, 1'b0});
        end
        3: begin
          // variance saturates, full gain swings across the whole range
          send_beat('{32'h0000_0000, 20'h0_0000, 1'b1});
          send_beat('{32'h7FFF_FFFF, 20'hF_FFFF, 1'b0});
          send_beat('{32'h8000_0000, 20'hF_FFFF, 1'b0});
        end
        default: ;
      endcase

      send_random((ph == 0) ? 300 : (ph == 1) ? 60 : 240);
    end

    drain_results();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
